// ===== rtl/ppu_pkg.sv =====
// Shared types, constants and helper functions for the packed-pixel unpacker.
// Used by the channel interfaces and all rtl modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ppu_pkg;

  localparam int BYTE_W            = 8;
  localparam int DEPTH_W           = 5;
  localparam int DIM_W             = 13;
  localparam int PEND_W            = 31;
  localparam int COUNT_W           = 5;
  localparam int PIX_W             = 24;
  localparam int CHAN_W            = 8;
  localparam int CFG_IDX_W         = 4;
  localparam int CFG_DATA_W        = 13;
  localparam int MAX_DIMENSION_DEF = 4096;

  localparam logic [DEPTH_W-1:0] DEPTH_MIN = 5'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 5'd24;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 4'd3;

  localparam logic [DEPTH_W-1:0] RST_PIXEL_DEPTH = 5'd24;
  localparam logic               RST_GRAY_MODE   = 1'b0;
  localparam logic [DIM_W-1:0]   RST_ROW_PIXELS  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_ROWS  = 13'd480;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               gray;
    logic [DIM_W-1:0]   row_pixels;
    logic [DIM_W-1:0]   frame_rows;
  } cfg_t;

  // depth / 3 for depth 1..24: multiply by 11, drop 5 bits
  function automatic logic [3:0] third_of(input logic [DEPTH_W-1:0] d);
    logic [9:0] prod;
    prod = 10'(d) * 10'd11;
    return prod[8:5];
  endfunction

  function automatic logic [CHAN_W-1:0] chan_mask(input logic [4:0] len);
    logic [8:0] m;
    m = (9'd1 << len[3:0]) - 9'd1;
    return (len >= 5'd8) ? 8'hFF : m[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ppu_ifs.sv =====
// Valid/ready channel interfaces: memory byte stream, pixel stream, config writes.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppu_byte_if;
  logic                        valid;
  logic                        ready;
  logic [ppu_pkg::BYTE_W-1:0]  mem_byte;
  modport source (output valid, output mem_byte, input ready);
  modport sink   (input valid, input mem_byte, output ready);
endinterface

interface ppu_pix_if;
  logic                        valid;
  logic                        ready;
  logic [ppu_pkg::CHAN_W-1:0]  blue_value;
  logic [ppu_pkg::CHAN_W-1:0]  green_value;
  logic [ppu_pkg::CHAN_W-1:0]  red_value;
  logic                        row_end;
  logic                        frame_end;
  logic                        last_of_byte;
  modport source (output valid, output blue_value, output green_value, output red_value,
                  output row_end, output frame_end, output last_of_byte, input ready);
  modport sink   (input valid, input blue_value, input green_value, input red_value,
                  input row_end, input frame_end, input last_of_byte, output ready);
endinterface

interface ppu_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppu_pkg::CFG_IDX_W-1:0]   index;
  logic [ppu_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ppu_cfg_regs.sv =====
// Configuration register file; depth clamped to its legal range on the way out.
// Depends on ppu_pkg and ppu_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module ppu_cfg_regs (
  input  wire logic      clk,
  input  wire logic      rst,
  ppu_cfg_if.sink        cfg,
  output ppu_pkg::cfg_t  regs
);

  logic [ppu_pkg::DEPTH_W-1:0] pixel_depth;
  logic                        gray_mode;
  logic [ppu_pkg::DIM_W-1:0]   row_pixels;
  logic [ppu_pkg::DIM_W-1:0]   frame_rows;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth <= ppu_pkg::RST_PIXEL_DEPTH;
      gray_mode   <= ppu_pkg::RST_GRAY_MODE;
      row_pixels  <= ppu_pkg::RST_ROW_PIXELS;
      frame_rows  <= ppu_pkg::RST_FRAME_ROWS;
    end else if (cfg.valid) begin
      case (cfg.index)
        ppu_pkg::REG_PIXEL_DEPTH: pixel_depth <= cfg.data[ppu_pkg::DEPTH_W-1:0];
        ppu_pkg::REG_GRAY_MODE:   gray_mode   <= cfg.data[0];
        ppu_pkg::REG_ROW_PIXELS:  row_pixels  <= cfg.data[ppu_pkg::DIM_W-1:0];
        ppu_pkg::REG_FRAME_ROWS:  frame_rows  <= cfg.data[ppu_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    regs.gray       = gray_mode;
    regs.row_pixels = row_pixels;
    regs.frame_rows = frame_rows;
    if (pixel_depth < ppu_pkg::DEPTH_MIN) begin
      regs.depth = ppu_pkg::DEPTH_MIN;
    end else if (pixel_depth > ppu_pkg::DEPTH_MAX) begin
      regs.depth = ppu_pkg::DEPTH_MAX;
    end else begin
      regs.depth = pixel_depth;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppu_unpack.sv =====
// Unpack sequencer: bit accumulator, shared depth shifter, channel split, output register.
// Depends on ppu_pkg, ppu_byte_if and ppu_pix_if.
`timescale 1ns / 1ps
`default_nettype none

module ppu_unpack #(
  parameter int MAX_DIMENSION = ppu_pkg::MAX_DIMENSION_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  ppu_pkg::cfg_t regs,
  ppu_byte_if.sink      bytes,
  ppu_pix_if.source     pixels
);

  localparam int CW = $clog2(MAX_DIMENSION);
  localparam int DW = (CW + 1 > ppu_pkg::DIM_W) ? CW + 1 : ppu_pkg::DIM_W;
  localparam logic [DW-1:0] MaxDim = DW'(MAX_DIMENSION);

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_UNPACK = 1'b1;

  function automatic logic [DW-1:0] clamp_dim(input logic [ppu_pkg::DIM_W-1:0] v);
    logic [DW-1:0] w;
    w = DW'(v);
    if (w == '0) return DW'(1);
    if (w > MaxDim) return MaxDim;
    return w;
  endfunction

  logic                          state;
  logic [ppu_pkg::PEND_W-1:0]    pend;
  logic [ppu_pkg::COUNT_W-1:0]   count;
  logic [CW-1:0]                 col;
  logic [CW-1:0]                 row;
  logic                          out_valid;
  logic [2:0]                    burst;

  logic [DW-1:0]                 cols_eff, rows_eff, col_inc, row_inc;
  logic                          have, slot_free, load, row_end_now, frame_end_now, last_px;
  logic [ppu_pkg::COUNT_W-1:0]   rem;
  logic [ppu_pkg::PIX_W-1:0]     pix_mask, pix;
  logic [3:0]                    lrb;
  logic [4:0]                    lg, red_pos;
  logic [ppu_pkg::CHAN_W-1:0]    blue, green, red;

  always_comb begin
    cols_eff      = clamp_dim(regs.row_pixels);
    rows_eff      = clamp_dim(regs.frame_rows);
    col_inc       = DW'(col) + DW'(1);
    row_inc       = DW'(row) + DW'(1);
    row_end_now   = col_inc >= cols_eff;
    frame_end_now = row_end_now && (row_inc >= rows_eff);

    have      = (state == ST_UNPACK) && (count >= regs.depth);
    rem       = count - regs.depth;
    last_px   = row_end_now || (rem < regs.depth) || (burst == 3'd7);
    slot_free = !out_valid || pixels.ready;
    load      = have && slot_free;

    pix_mask = ppu_pkg::PIX_W'((32'h1 << regs.depth) - 32'h1);
    pix      = pend[ppu_pkg::PIX_W-1:0] & pix_mask;
    lrb      = ppu_pkg::third_of(regs.depth);
    lg       = regs.depth - {lrb, 1'b0};
    red_pos  = {1'b0, lrb} + lg;
    if (regs.gray) begin
      blue  = pix[ppu_pkg::CHAN_W-1:0];
      green = pix[ppu_pkg::CHAN_W-1:0];
      red   = pix[ppu_pkg::CHAN_W-1:0];
    end else begin
      blue  = pix[ppu_pkg::CHAN_W-1:0] & ppu_pkg::chan_mask({1'b0, lrb});
      green = ppu_pkg::CHAN_W'(pix >> lrb) & ppu_pkg::chan_mask(lg);
      red   = ppu_pkg::CHAN_W'(pix >> red_pos) & ppu_pkg::chan_mask({1'b0, lrb});
    end
  end

  assign bytes.ready = (state == ST_ACCEPT);
  assign pixels.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCEPT;
      pend      <= '0;
      count     <= '0;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
      burst     <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pixels.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_ACCEPT: begin
          if (bytes.valid) begin
            pend  <= pend | (ppu_pkg::PEND_W'(bytes.mem_byte) << count);
            count <= count + 5'd8;
            burst <= '0;
            state <= ST_UNPACK;
          end
        end
        ST_UNPACK: begin
          if (!have) begin
            state <= ST_ACCEPT;
          end else if (slot_free) begin
            if (row_end_now) begin
              pend  <= '0;
              count <= '0;
              col   <= '0;
              row   <= frame_end_now ? '0 : CW'(row_inc);
            end else begin
              pend  <= pend >> regs.depth;
              count <= rem;
              col   <= CW'(col_inc);
            end
            burst <= burst + 3'd1;
            if (last_px) state <= ST_ACCEPT;
          end
        end
        default: state <= ST_ACCEPT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixels.blue_value   <= blue;
      pixels.green_value  <= green;
      pixels.red_value    <= red;
      pixels.row_end      <= row_end_now;
      pixels.frame_end    <= frame_end_now;
      pixels.last_of_byte <= last_px;
    end
  end

`ifndef SYNTHESIS
  a_frame_in_row: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && pixels.frame_end |-> pixels.row_end)
    else $error("frame end without row end");

  a_row_clears: assert property (@(posedge clk) disable iff (rst)
    load && row_end_now |=> count == '0 && pend == '0 && state == ST_ACCEPT)
    else $error("row end did not drop padding bits");

  a_row_last: assert property (@(posedge clk) disable iff (rst)
    load && row_end_now |=> pixels.last_of_byte)
    else $error("row end pixel not flagged last of byte");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    bytes.valid && bytes.ready |=> state == ST_UNPACK && count >= 5'd8)
    else $error("accepted byte not merged");
`endif

endmodule

`default_nettype wire

// ===== rtl/packed_pixel_to_bgr24_unpacker.sv =====
// Packed-pixel to BGR24 unpacker, top level.
// Channels: bytes (sink) carries framebuffer memory bytes in address order, pixels
// (source) carries one BGR result per completed pixel with row, frame and
// last-of-byte flags, cfg (sink) writes pixel_depth, gray_mode, row_pixels and
// frame_rows by index 0..3; cfg is always ready. The user must write cfg only
// while idle; the block does not enforce it. A byte is taken in the accept state,
// then the unpack state emits each pixel it completes, or returns when it
// completes none. The single depth shifter and channel split handle one pixel a
// cycle; when the receiver stalls, the held pixel stays put and unpacking pauses.
// A result appears in the output register in the cycle after its shift step and
// the byte port stays low until the last pixel of the current byte is loaded.
// Reset (rst, synchronous) restores register defaults (depth 24, truecolor,
// 640 x 480), empties the bit accumulator and zeroes the row and column counts.
// Depends on ppu_pkg, the channel interfaces, ppu_cfg_regs and ppu_unpack.
`timescale 1ns / 1ps
`default_nettype none

module packed_pixel_to_bgr24_unpacker #(
  parameter int MAX_DIMENSION = ppu_pkg::MAX_DIMENSION_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ppu_cfg_if.sink    cfg,
  ppu_byte_if.sink   bytes,
  ppu_pix_if.source  pixels
);

  ppu_pkg::cfg_t regs;

  ppu_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ppu_unpack #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_unpack (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .bytes  (bytes),
    .pixels (pixels)
  );

endmodule

`default_nettype wire
